// ===== hw/rtl/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants of the integer text formatter
// Field widths, conversion kinds, flag positions, ASCII codes and the
// control/status structs between the top level and the digit generator.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

    localparam int VALUE_W  = 64;
    localparam int FWIDTH_W = 7;
    localparam int FLAGS_W  = 5;
    localparam int CHAR_W   = 8;

    typedef logic [1:0]          t_req_type;
    typedef logic [CHAR_W-1:0]   t_char;

    localparam t_req_type KIND_SDEC = 2'd0;
    localparam t_req_type KIND_UDEC = 2'd1;
    localparam t_req_type KIND_HEX  = 2'd2;
    localparam t_req_type KIND_PTR  = 2'd3;

    localparam int FLAG_ALT   = 0;
    localparam int FLAG_ZERO  = 1;
    localparam int FLAG_LEFT  = 2;
    localparam int FLAG_SPACE = 3;
    localparam int FLAG_PLUS  = 4;

    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_MINUS = 8'h2d;
    localparam t_char CH_PLUS  = 8'h2b;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_X     = 8'h78;
    localparam t_char CH_A_OFS = 8'h57;   // 'a' - 10

    typedef struct packed {
        logic load;
        logic hex;
        logic pop;
    } t_dg_ctrl;

    typedef struct packed {
        logic       done;
        logic [3:0] digit;
    } t_dg_stat;

    function automatic t_char digit_char(input logic [3:0] d);
        t_char c;
        if (d < 4'd10) begin
            c = CH_ZERO + t_char'(d);
        end else begin
            c = CH_A_OFS + t_char'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itf_req_if.sv =====
// ----------------------------------------------------------------------------
// itf_req_if: request channel of the integer text formatter
// Valid/ready handshake carrying one value to format with its options.
// ----------------------------------------------------------------------------
`default_nettype none

interface itf_req_if;
    import itf_pkg::*;

    logic                valid;
    logic                ready;
    t_req_type           req_type;
    logic [VALUE_W-1:0]  value;
    logic [FWIDTH_W-1:0] field_width;
    logic [FLAGS_W-1:0]  format_flags;

    modport source (output valid, output req_type, output value,
                    output field_width, output format_flags, input ready);
    modport sink   (input valid, input req_type, input value,
                    input field_width, input format_flags, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/itf_char_if.sv =====
// ----------------------------------------------------------------------------
// itf_char_if: character channel of the integer text formatter
// Valid/ready handshake carrying one ASCII character and its last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface itf_char_if;
    import itf_pkg::*;

    logic  valid;
    logic  ready;
    t_char out_char;
    logic  last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/integer_text_formatter_top.sv =====
// ----------------------------------------------------------------------------
// integer_text_formatter_top: formats one integer as an ASCII text field
// Signed/unsigned decimal, lowercase hex and pointer hex with sign, 0x
// prefix, minimum field width and space or zero padding.
// ----------------------------------------------------------------------------
// Usage:
//   i_req takes one transaction per value: kind, value, field width, flags.
//   o_char returns the field one character per transaction, last set on
//   the final character. Both channels use valid/ready.
//   Decimal kinds run a bit-serial BCD conversion; hex kinds load their
//   nibbles at once. Leading zero digits are then stripped one per cycle
//   (at most one less than the digit register depth, 20 at 64 bits). The
//   characters then follow one per cycle while o_char is not stalled.
//   i_req.ready is high only between items; it rises as soon as the last
//   character sits in the output register, before it is taken.
//   A stalled o_char holds the character and pauses the emit sequence.
//   Reset (synchronous, active low) empties the output register and
//   returns the block to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_text_formatter_top #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_WIDTH  = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    itf_req_if.sink     i_req,
    itf_char_if.source  o_char
);
    import itf_pkg::*;

    localparam int HEXD   = (VALUE_BITS + 3) / 4;
    localparam int DECD   = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int NDIG   = (DECD > HEXD) ? DECD : HEXD;
    localparam int NCW    = $clog2(NDIG + 1);
    localparam int TOTMAX = NDIG + 2;
    localparam int CW     = $clog2(((MAX_WIDTH > TOTMAX) ? MAX_WIDTH : TOTMAX) + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [1:0]  r_pre_cnt, n_pre_cnt;
    logic        r_is_0x, n_is_0x;
    t_char       r_sign_ch, n_sign_ch;
    logic        r_zero, n_zero;
    logic        r_left, n_left;
    logic [CW-1:0] r_width, n_width;
    logic [CW-1:0] r_padl, n_padl;
    logic [CW-1:0] r_padz, n_padz;
    logic [CW-1:0] r_padr, n_padr;
    logic        r_o_valid, n_o_valid;
    t_char       r_o_char, n_o_char;
    logic        r_o_last, n_o_last;

    t_dg_ctrl              dg_ctrl;
    t_dg_stat              dg_stat;
    logic [NCW-1:0]        dg_cnt;
    logic [VALUE_BITS-1:0] in_val;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic [FLAGS_W-1:0]    fl;
    logic [CW-1:0]         total;
    logic [CW-1:0]         pad;
    logic                  core_done;
    logic                  is_last;
    logic                  emit_go;

    itf_digit_gen #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_digit_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (dg_ctrl),
        .i_mag   (mag),
        .o_stat  (dg_stat),
        .o_cnt   (dg_cnt)
    );

    assign in_val = i_req.value[VALUE_BITS-1:0];
    assign fl     = i_req.format_flags;
    assign neg    = (i_req.req_type == KIND_SDEC) && in_val[VALUE_BITS-1];
    assign mag    = neg ? (~in_val + VALUE_BITS'(1)) : in_val;

    assign total = CW'(r_pre_cnt) + CW'(dg_cnt);
    assign pad   = (r_width > total) ? (r_width - total) : '0;

    assign core_done = (r_padl == '0) && (r_pre_cnt == 2'd0) && (r_padz == '0);
    assign is_last   = core_done && ((dg_cnt == NCW'(1) && r_padr == '0) ||
                                     (dg_cnt == '0 && r_padr == CW'(1)));
    assign emit_go   = !r_o_valid || o_char.ready;

    always_comb begin
        n_state   = r_state;
        n_pre_cnt = r_pre_cnt;
        n_is_0x   = r_is_0x;
        n_sign_ch = r_sign_ch;
        n_zero    = r_zero;
        n_left    = r_left;
        n_width   = r_width;
        n_padl    = r_padl;
        n_padz    = r_padz;
        n_padr    = r_padr;
        n_o_valid = r_o_valid && !o_char.ready;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        dg_ctrl   = '0;
        dg_ctrl.hex = i_req.req_type[1];

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    dg_ctrl.load = 1'b1;
                    n_left  = fl[FLAG_LEFT];
                    n_zero  = fl[FLAG_ZERO] && !fl[FLAG_LEFT];
                    n_width = (i_req.field_width > FWIDTH_W'(MAX_WIDTH)) ?
                              CW'(MAX_WIDTH) : CW'(i_req.field_width);
                    n_is_0x   = 1'b0;
                    n_pre_cnt = 2'd0;
                    n_sign_ch = CH_SPACE;
                    if (i_req.req_type == KIND_SDEC) begin
                        if (neg) begin
                            n_sign_ch = CH_MINUS;
                            n_pre_cnt = 2'd1;
                        end else if (fl[FLAG_PLUS]) begin
                            n_sign_ch = CH_PLUS;
                            n_pre_cnt = 2'd1;
                        end else if (fl[FLAG_SPACE]) begin
                            n_pre_cnt = 2'd1;
                        end
                    end else if (i_req.req_type == KIND_PTR ||
                                 (i_req.req_type == KIND_HEX && fl[FLAG_ALT])) begin
                        n_is_0x   = 1'b1;
                        n_pre_cnt = 2'd2;
                    end
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (dg_stat.done) begin
                    n_padl = '0;
                    n_padz = '0;
                    n_padr = '0;
                    if (r_left) begin
                        n_padr = pad;
                    end else if (r_zero) begin
                        n_padz = pad;
                    end else begin
                        n_padl = pad;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_o_valid = 1'b1;
                    n_o_last  = is_last;
                    if (r_padl != '0) begin
                        n_o_char = CH_SPACE;
                        n_padl   = r_padl - CW'(1);
                    end else if (r_pre_cnt != 2'd0) begin
                        if (r_is_0x) begin
                            n_o_char = (r_pre_cnt == 2'd2) ? CH_ZERO : CH_X;
                        end else begin
                            n_o_char = r_sign_ch;
                        end
                        n_pre_cnt = r_pre_cnt - 2'd1;
                    end else if (r_padz != '0) begin
                        n_o_char = CH_ZERO;
                        n_padz   = r_padz - CW'(1);
                    end else if (dg_cnt != '0) begin
                        n_o_char    = digit_char(dg_stat.digit);
                        dg_ctrl.pop = 1'b1;
                    end else begin
                        n_o_char = CH_SPACE;
                        n_padr   = r_padr - CW'(1);
                    end
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre_cnt <= n_pre_cnt;
        r_is_0x   <= n_is_0x;
        r_sign_ch <= n_sign_ch;
        r_zero    <= n_zero;
        r_left    <= n_left;
        r_width   <= n_width;
        r_padl    <= n_padl;
        r_padz    <= n_padz;
        r_padr    <= n_padr;
        r_o_char  <= n_o_char;
        r_o_last  <= n_o_last;
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_char.valid    = r_o_valid;
    assign o_char.out_char = r_o_char;
    assign o_char.last     = r_o_last;

endmodule

`default_nettype wire

// ===== hw/rtl/itf_digit_gen.sv =====
// ----------------------------------------------------------------------------
// itf_digit_gen: digit register with bit-serial binary to BCD conversion
// Loads a magnitude as hex nibbles or converts it to BCD one bit per cycle
// (shift and add-3), strips leading zero digits one per cycle, then hands
// the digits out most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_digit_gen #(
    parameter int VALUE_BITS = 64,
    parameter int NDIG       = 20
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  itf_pkg::t_dg_ctrl            i_ctrl,
    input  wire [VALUE_BITS-1:0]         i_mag,
    output itf_pkg::t_dg_stat            o_stat,
    output logic [$clog2(NDIG+1)-1:0]    o_cnt
);
    import itf_pkg::*;

    localparam int DW  = NDIG * 4;
    localparam int NCW = $clog2(NDIG + 1);
    localparam int IW  = $clog2(VALUE_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_NORM = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [DW-1:0]         r_dig, n_dig;
    logic [NCW-1:0]        r_cnt, n_cnt;
    logic [IW-1:0]         r_iter, n_iter;
    logic [DW-1:0]         adj;
    logic [3:0]            top_nib;

    assign top_nib = r_dig[DW-1 -: 4];

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            if (r_dig[k*4 +: 4] >= 4'd5) begin
                adj[k*4 +: 4] = r_dig[k*4 +: 4] + 4'd3;
            end else begin
                adj[k*4 +: 4] = r_dig[k*4 +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_val   = r_val;
        n_dig   = r_dig;
        n_cnt   = r_cnt;
        n_iter  = r_iter;
        if (i_ctrl.load) begin
            n_cnt  = NCW'(NDIG);
            n_iter = IW'(VALUE_BITS - 1);
            n_val  = i_mag;
            if (i_ctrl.hex) begin
                n_dig   = DW'(i_mag);
                n_state = S_NORM;
            end else begin
                n_dig   = '0;
                n_state = S_CONV;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                end
                S_CONV: begin
                    n_dig  = {adj[DW-2:0], r_val[VALUE_BITS-1]};
                    n_val  = {r_val[VALUE_BITS-2:0], 1'b0};
                    n_iter = r_iter - IW'(1);
                    if (r_iter == '0) begin
                        n_state = S_NORM;
                    end
                end
                S_NORM: begin
                    // drop one leading zero digit, keep at least one
                    if (r_cnt > NCW'(1) && top_nib == 4'd0) begin
                        n_dig = {r_dig[DW-5:0], 4'd0};
                        n_cnt = r_cnt - NCW'(1);
                    end else begin
                        n_state = S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ctrl.pop) begin
                        n_dig = {r_dig[DW-5:0], 4'd0};
                        n_cnt = r_cnt - NCW'(1);
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_dig  <= n_dig;
        r_cnt  <= n_cnt;
        r_iter <= n_iter;
    end

    assign o_stat.done  = (r_state == S_DONE);
    assign o_stat.digit = top_nib;
    assign o_cnt        = r_cnt;

endmodule

`default_nettype wire
